// File: src/trd_pkg.sv
package trd_pkg;

	localparam int unsigned PIX_CNT_W = 25;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 25;

	localparam logic [PIX_CNT_W-1:0] MAX_PIXELS = 25'd16777216;

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL = 2'd2;

	localparam logic [2:0] BPP_BGR = 3'd3;
	localparam logic [2:0] BPP_BGRA = 3'd4;

	// Byte position of the last byte of a pixel.
	localparam logic [1:0] LAST_POS_BGR = 2'd2;
	localparam logic [1:0] LAST_POS_BGRA = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       image_last;
	} pixel_t;

endpackage

// File: src/trd_core.sv
module trd_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [trd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             byte_accept,
	input  logic [7:0]                       data_byte,
	output logic                             res_valid,
	output trd_pkg::pixel_t                  res
);
	import trd_pkg::*;

	logic [2:0]           bytes_per_pixel_q;
	logic                 compressed_mode_q;
	logic [PIX_CNT_W-1:0] pixel_total_q;

	logic                 awaiting_header_q;
	logic                 run_packet_q;
	logic [7:0]           packet_pixels_left_q;
	logic [1:0]           byte_position_q;
	logic [7:0]           pixel_bytes_q [3];
	logic [PIX_CNT_W-1:0] image_pixels_left_q;

	logic                 start;
	logic                 bgra;
	logic [PIX_CNT_W-1:0] eff_total;
	logic [PIX_CNT_W-1:0] ipl_eff;
	logic                 ah_eff;
	logic                 rp_eff;
	logic [7:0]           ppl_eff;
	logic [1:0]           bp_eff;
	logic                 ah_d;
	logic                 rp_d;
	logic [7:0]           ppl_d;
	logic [1:0]           bp_d;
	logic [PIX_CNT_W-1:0] ipl_d;
	logic                 store_byte;
	logic                 pix_done;
	logic [7:0]           count_raw;
	logic [7:0]           rep_raw;
	logic [7:0]           rep;
	logic                 cfg_hit;

	assign bgra = (bytes_per_pixel_q == BPP_BGRA);
	assign cfg_hit = cfg_wr_en && (cfg_index == REG_BYTES_PER_PIXEL
		|| cfg_index == REG_COMPRESSED_MODE || cfg_index == REG_PIXEL_TOTAL);

	always_comb begin
		if (pixel_total_q == '0) begin
			eff_total = PIX_CNT_W'(1);
		end else if (pixel_total_q > MAX_PIXELS) begin
			eff_total = MAX_PIXELS;
		end else begin
			eff_total = pixel_total_q;
		end
	end

	always_comb begin
		// A zero pixel count means no image is open; this byte starts one.
		start = (image_pixels_left_q == '0);
		ipl_eff = start ? eff_total : image_pixels_left_q;
		ah_eff = start ? 1'b1 : awaiting_header_q;
		rp_eff = start ? 1'b0 : run_packet_q;
		ppl_eff = start ? 8'd0 : packet_pixels_left_q;
		bp_eff = start ? 2'd0 : byte_position_q;

		ah_d = ah_eff;
		rp_d = rp_eff;
		ppl_d = ppl_eff;
		bp_d = bp_eff;
		ipl_d = ipl_eff;
		store_byte = 1'b0;
		res_valid = 1'b0;
		rep_raw = 8'd1;
		rep = 8'd1;
		count_raw = {1'b0, data_byte[6:0]} + 8'd1;
		pix_done = (bp_eff == (bgra ? LAST_POS_BGRA : LAST_POS_BGR));

		if (compressed_mode_q && ah_eff) begin
			// Packet header: clamp the packet to the pixels left in the image.
			ppl_d = (ipl_eff < PIX_CNT_W'(count_raw)) ? ipl_eff[7:0] : count_raw;
			rp_d = data_byte[7];
			ah_d = 1'b0;
		end else begin
			store_byte = 1'b1;
			if (!pix_done) begin
				bp_d = bp_eff + 2'd1;
			end else begin
				bp_d = 2'd0;
				res_valid = 1'b1;
				if (compressed_mode_q && rp_eff) begin
					rep_raw = ppl_eff;
					ppl_d = 8'd0;
				end else if (compressed_mode_q) begin
					ppl_d = ppl_eff - 8'd1;
				end
				if (compressed_mode_q && ppl_d == 8'd0) begin
					ah_d = 1'b1;
				end
				if (rep_raw == 8'd0) begin
					rep_raw = 8'd1;
				end
				rep = (ipl_eff < PIX_CNT_W'(rep_raw)) ? ipl_eff[7:0] : rep_raw;
				ipl_d = ipl_eff - PIX_CNT_W'(rep);
			end
		end

		res.blue = bp_eff == 2'd0 ? data_byte : pixel_bytes_q[0];
		res.green = pixel_bytes_q[1];
		res.red = bgra ? pixel_bytes_q[2] : data_byte;
		res.alpha = bgra ? data_byte : 8'd0;
		res.repeat_count = rep;
		res.image_last = (ipl_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q <= BPP_BGR;
			compressed_mode_q <= 1'b0;
			pixel_total_q <= PIX_CNT_W'(1);
			awaiting_header_q <= 1'b1;
			run_packet_q <= 1'b0;
			packet_pixels_left_q <= 8'd0;
			byte_position_q <= 2'd0;
			image_pixels_left_q <= '0;
		end else if (cfg_hit) begin
			// Any register write abandons the image in progress.
			case (cfg_index)
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[2:0];
				REG_COMPRESSED_MODE: compressed_mode_q <= cfg_data[0];
				REG_PIXEL_TOTAL:     pixel_total_q <= cfg_data[PIX_CNT_W-1:0];
				default:             pixel_total_q <= pixel_total_q;
			endcase
			awaiting_header_q <= 1'b1;
			run_packet_q <= 1'b0;
			packet_pixels_left_q <= 8'd0;
			byte_position_q <= 2'd0;
			image_pixels_left_q <= '0;
		end else if (byte_accept) begin
			awaiting_header_q <= ah_d;
			run_packet_q <= rp_d;
			packet_pixels_left_q <= ppl_d;
			byte_position_q <= bp_d;
			image_pixels_left_q <= ipl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept && store_byte && bp_eff != 2'd3) begin
			pixel_bytes_q[bp_eff] <= data_byte;
		end
	end

endmodule

// File: src/trd_obuf.sv
module trd_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  trd_pkg::pixel_t push_data,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop,
	output trd_pkg::pixel_t pop_data
);
	import trd_pkg::*;

	pixel_t     entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/tga_rle_pixel_decoder_top.sv
// Targa pixel-data decoder. One data byte is taken per transaction; a byte can
// be accepted every clock unless in_stall is high. Header bytes and bytes that
// do not finish a pixel give no result. A finished pixel enters the output
// buffer with the byte that completes it, with blue and red in their named
// fields and a run packet reported once with its repeat count. Results wait in
// a two-entry output buffer, so the input stalls only while both entries are
// held by a stalled output. Any register write abandons the image in progress;
// the next byte starts one of pixel_total pixels, clamped to 1..MAX_PIXELS.
module tga_rle_pixel_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [trd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [7:0]                     alpha,
	output logic [7:0]                     repeat_count,
	output logic                           image_last
);
	import trd_pkg::*;

	logic   byte_accept;
	logic   res_valid;
	pixel_t res;
	logic   buf_full;
	pixel_t out_pix;

	assign in_stall = buf_full;
	assign byte_accept = in_valid && !buf_full;

	trd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_accept (byte_accept),
		.data_byte   (data_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	trd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (byte_accept && res_valid),
		.push_data (res),
		.full      (buf_full),
		.pop_valid (out_valid),
		.pop       (!out_stall),
		.pop_data  (out_pix)
	);

	assign red = out_pix.red;
	assign green = out_pix.green;
	assign blue = out_pix.blue;
	assign alpha = out_pix.alpha;
	assign repeat_count = out_pix.repeat_count;
	assign image_last = out_pix.image_last;

endmodule
